// File: sv/accel_boxcar_ema_filter_unit_defines.svh
// Assertion macros for the accelerometer filter checker.
// Depends on signals clk and arst_n being visible where a macro is used.
`ifndef ACCEL_BOXCAR_EMA_FILTER_UNIT_DEFINES_SVH
`define ACCEL_BOXCAR_EMA_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, gated off during reset
`define ABEF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("abef check failed");

// next-cycle implication, gated off during reset
`define ABEF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("abef check failed");

`endif

// File: sv/abef_pkg.sv
// Shared types, constants and helpers for the accelerometer filter.
// No dependencies; used by all other files of the block but the macro header.
`default_nettype none

package abef_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int CFG_W         = 17;
	localparam int OUT_W         = 25;
	localparam int AVG_W         = 24;       // sample with 8 fractional bits
	localparam int FRAC_BITS     = 8;
	localparam int DIFF_W        = OUT_W + 1;
	localparam int DEPTH_DEFAULT = 16;

	localparam logic [CFG_W-1:0] FACTOR_RESET = 17'd6554;
	localparam logic [CFG_W-1:0] FACTOR_ONE   = 17'h10000;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 25'sh0FFFFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = -25'sh1000000;

	typedef enum logic [1:0] {
		REG_FACTOR   = 2'd0,
		REG_OFFSET_X = 2'd1,
		REG_OFFSET_Y = 2'd2
	} reg_idx_t;

	// pipeline control shared with the per-axis datapath
	typedef struct packed {
		logic adv;
		logic v1;
		logic v2;
		logic v3;
	} pipe_ctl_t;

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [DIFF_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > DIFF_W'(OUT_MAX)) begin
			r = OUT_MAX;
		end else if (v < DIFF_W'(OUT_MIN)) begin
			r = OUT_MIN;
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/abef_if.sv
// Valid/ready channel interfaces: raw sample pairs in, filtered g values out.
// Depends on abef_pkg for field widths.
`default_nettype none

interface abef_sample_if import abef_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_x;
	logic signed [SAMPLE_W-1:0] sample_y;

	modport source (output valid, output sample_x, output sample_y, input ready);
	modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

interface abef_accel_if import abef_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] accel_x_g;
	logic signed [OUT_W-1:0] accel_y_g;

	modport source (output valid, output accel_x_g, output accel_y_g, input ready);
	modport sink   (input valid, input accel_x_g, input accel_y_g, output ready);
endinterface

`default_nettype wire

// File: sv/accel_boxcar_ema_filter_unit.sv
// Top level of the two-axis accelerometer filter.
// Depends on abef_pkg, abef_if, abef_ring and abef_axis.
`default_nettype none

// Two-axis accelerometer filter. Every accepted sample pair yields exactly one
// result pair. Each axis averages its last DEPTH samples (DEPTH a power of two,
// 2..256), smooths that average exponentially with weight smoothing_factor
// (1.16 unsigned, values above 1.0 act as 1.0), removes the axis offset and
// reports g with 22 fractional bits, saturated to 25 bits. Throughput is one
// item per clock. The ring memory does one read-before-write per item on a
// single port, and the smoothing state closes a multiply-accumulate loop, which
// together set that pace. The output register hands its result over and takes
// the next one in the same cycle; while a result waits on the result side the
// whole pipeline holds and the input is blocked. Reset takes effect at once:
// ring entries carry valid bits, so no clearing pass is needed. Configuration
// (index 0 smoothing_factor, 1 offset_x, 2 offset_y) must be written only
// while idle; the block itself does not enforce this.

module accel_boxcar_ema_filter_unit import abef_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_idx,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	abef_sample_if.sink           sample_ch,
	abef_accel_if.source          accel_ch
);

	localparam int LG = $clog2(DEPTH);

	// configuration
	logic        [CFG_W-1:0]    factor_q;
	logic signed [SAMPLE_W-1:0] offset_x_q;
	logic signed [SAMPLE_W-1:0] offset_y_q;
	logic        [CFG_W-1:0]    factor_eff;

	// pipeline control
	logic          adv;
	logic          accept;
	logic          v1_q, v2_q, v3_q, v4_q, out_v_q;
	pipe_ctl_t     ctl;
	logic [LG-1:0] slot_q;

	// datapath
	logic signed [SAMPLE_W-1:0] x_s1, y_s1;
	logic        [2*SAMPLE_W-1:0] ring_rd;
	logic signed [AVG_W-1:0]    smooth_x, smooth_y;
	logic signed [DIFF_W-1:0]   diff_x, diff_y;
	logic signed [OUT_W-1:0]    accel_x_q, accel_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q   <= FACTOR_RESET;
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_FACTOR:   factor_q   <= cfg_wdata;
				REG_OFFSET_X: offset_x_q <= cfg_wdata[SAMPLE_W-1:0];
				REG_OFFSET_Y: offset_y_q <= cfg_wdata[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// weights above 1.0 clamp to 1.0
	assign factor_eff = factor_q[CFG_W-1] ? FACTOR_ONE : factor_q;

	// whole pipeline moves whenever the output register is free or draining
	assign adv             = !out_v_q || accel_ch.ready;
	assign accept          = sample_ch.valid && adv;
	assign sample_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			v4_q    <= 1'b0;
			out_v_q <= 1'b0;
			slot_q  <= '0;
		end else begin
			if (adv) begin
				v1_q    <= accept;
				v2_q    <= v1_q;
				v3_q    <= v2_q;
				v4_q    <= v3_q;
				out_v_q <= v4_q;
			end
			if (accept) begin
				slot_q <= slot_q + 1'b1;   // wraps at DEPTH
			end
		end
	end

	assign ctl = '{adv: adv, v1: v1_q, v2: v2_q, v3: v3_q};

	// new samples stay put until the next accept; the axes use them in s1
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= sample_ch.sample_x;
			y_s1 <= sample_ch.sample_y;
		end
	end

	// both axes share one ring entry: {x, y}
	abef_ring #(
		.DEPTH (DEPTH),
		.WIDTH (2 * SAMPLE_W)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.addr   (slot_q),
		.wdata  ({sample_ch.sample_x, sample_ch.sample_y}),
		.rdata  (ring_rd)
	);

	abef_axis #(.DEPTH(DEPTH)) u_axis_x (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sample_new (x_s1),
		.sample_old ($signed(ring_rd[2*SAMPLE_W-1:SAMPLE_W])),
		.factor     (factor_eff),
		.smooth     (smooth_x)
	);

	abef_axis #(.DEPTH(DEPTH)) u_axis_y (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sample_new (y_s1),
		.sample_old ($signed(ring_rd[SAMPLE_W-1:0])),
		.factor     (factor_eff),
		.smooth     (smooth_y)
	);

	// counts/16384 in Q22 equals counts in Q8, so the offset just shifts by 8
	assign diff_x = DIFF_W'(smooth_x) - DIFF_W'($signed({offset_x_q, 8'h00}));
	assign diff_y = DIFF_W'(smooth_y) - DIFF_W'($signed({offset_y_q, 8'h00}));

	always_ff @(posedge clk) begin
		if (adv && v4_q) begin
			accel_x_q <= sat_out(diff_x);
			accel_y_q <= sat_out(diff_y);
		end
	end

	assign accel_ch.valid     = out_v_q;
	assign accel_ch.accel_x_g = accel_x_q;
	assign accel_ch.accel_y_g = accel_y_q;

endmodule

`default_nettype wire

// File: sv/abef_ring.sv
// Sample ring: one single-port memory, read-before-write, with per-entry valid bits.
// Depends on abef_pkg.
`default_nettype none

module abef_ring import abef_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int WIDTH = 2 * SAMPLE_W
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;
	logic [DEPTH-1:0] vld_q;
	logic             hit_q;

	// old contents come out, new sample goes in, same address
	always_ff @(posedge clk) begin
		if (en) begin
			rd_q      <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	// never-written entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else if (en) begin
			hit_q       <= vld_q[addr];
			vld_q[addr] <= 1'b1;
		end
	end

	assign rdata = hit_q ? rd_q : '0;

endmodule

`default_nettype wire

// File: sv/abef_axis.sv
// One axis datapath: running boxcar sum, weighted average, smoothing MAC loop.
// Depends on abef_pkg.
`default_nettype none

module abef_axis import abef_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire pipe_ctl_t                  ctl,
	input  wire logic signed [SAMPLE_W-1:0] sample_new,
	input  wire logic signed [SAMPLE_W-1:0] sample_old,
	input  wire logic        [CFG_W-1:0]    factor,
	output logic signed      [AVG_W-1:0]    smooth
);

	localparam int LG     = $clog2(DEPTH);
	localparam int SUM_W  = SAMPLE_W + LG;
	localparam int SHIFT  = FRAC_BITS - LG;
	localparam int WGT_W  = CFG_W + 1;
	localparam int PROD_W = AVG_W + WGT_W;
	localparam int ACC_W  = PROD_W + 1;

	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SUM_W-1:0]  sum_nxt;
	logic signed [SUM_W-1:0]  sum_s2;
	logic signed [AVG_W-1:0]  avg;
	logic signed [WGT_W-1:0]  wgt_new;
	logic signed [WGT_W-1:0]  wgt_old;
	logic signed [PROD_W-1:0] prod_new;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [ACC_W-1:0]  acc;
	logic signed [AVG_W-1:0]  smooth_q;

	assign sum_nxt  = sum_q - SUM_W'(sample_old) + SUM_W'(sample_new);
	// sum * 256 / DEPTH, exact
	assign avg      = AVG_W'(sum_s2) <<< SHIFT;
	assign wgt_new  = $signed({1'b0, factor});
	assign wgt_old  = $signed({1'b0, FACTOR_ONE}) - wgt_new;
	assign prod_new = PROD_W'(avg) * PROD_W'(wgt_new);
	// prev*(1-a) + avg*a, round half up
	assign acc      = ACC_W'(prod_s3) + ACC_W'(smooth_q) * ACC_W'(wgt_old)
	                + ACC_W'(1 <<< 15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			smooth_q <= '0;
		end else if (ctl.adv) begin
			if (ctl.v1) begin
				sum_q <= sum_nxt;
			end
			if (ctl.v3) begin
				smooth_q <= AVG_W'(acc >>> 16);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			if (ctl.v1) begin
				sum_s2 <= sum_nxt;
			end
			if (ctl.v2) begin
				prod_s3 <= prod_new;
			end
		end
	end

	assign smooth = smooth_q;

endmodule

`default_nettype wire

// File: sv/abef_checker.sv
// Port-level checks for the accelerometer filter, bound to the top level.
// Depends on abef_pkg and accel_boxcar_ema_filter_unit_defines.svh.
`default_nettype none

`include "accel_boxcar_ema_filter_unit_defines.svh"

module abef_checker import abef_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_ready,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic signed [OUT_W-1:0] accel_x_g,
	input wire logic signed [OUT_W-1:0] accel_y_g
);

	// a waiting result stays offered
	`ABEF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	// and its values do not move
	`ABEF_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(accel_x_g) && $stable(accel_y_g))
	// an empty output register never blocks the input
	`ABEF_ASSERT_IMP(a_in_free, !out_valid, in_ready)
	// a stalled result stalls the input
	`ABEF_ASSERT_IMP(a_in_stall, out_valid && !out_ready, !in_ready)

endmodule

bind accel_boxcar_ema_filter_unit abef_checker u_abef_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sample_ch.ready),
	.out_valid (accel_ch.valid),
	.out_ready (accel_ch.ready),
	.accel_x_g (accel_ch.accel_x_g),
	.accel_y_g (accel_ch.accel_y_g)
);

`default_nettype wire

// File: tb/accel_boxcar_ema_filter_unit_tb.sv
// Self-checking testbench for the two-axis accelerometer filter.
// Depends on abef_pkg, abef_if and accel_boxcar_ema_filter_unit; includes no files.
`default_nettype none

module accel_boxcar_ema_filter_unit_tb import abef_pkg::*; ();

	// ring size must match the DEPTH the block is built with (default)
	localparam int RING_DEPTH     = DEPTH_DEFAULT;
	localparam int AVG_SCALE      = 256 / RING_DEPTH;
	localparam int PIPE_SETTLE    = 8;    // idle cycles waited after a drain
	localparam int LONG_HOLD      = 64;   // long receiver hold-off, enough to back up the pipe
	localparam int WATCHDOG_LIMIT = 1000; // cycles without any accepted item
	localparam int PHASE_ITEMS    = 100;
	localparam int RANDOM_PHASES  = 6;

	typedef struct packed {
		logic signed [OUT_W-1:0] ax;
		logic signed [OUT_W-1:0] ay;
	} accel_pair_t;

	// Scoreboard: keeps its own copy of the rings, sums, smoothing state and
	// registers, predicts the g pair for every accepted sample pair and checks
	// the results in order.
	class accel_scoreboard;
		int                         ring_x[RING_DEPTH];
		int                         ring_y[RING_DEPTH];
		int                         sum_x;
		int                         sum_y;
		int                         slot;
		longint                     smooth_x;
		longint                     smooth_y;
		logic [CFG_W-1:0]           factor;
		logic signed [SAMPLE_W-1:0] off_x;
		logic signed [SAMPLE_W-1:0] off_y;
		accel_pair_t                pending_g[$];
		int                         errors;

		function new();
			foreach (ring_x[i]) begin
				ring_x[i] = 0;
				ring_y[i] = 0;
			end
			sum_x    = 0;
			sum_y    = 0;
			slot     = 0;
			smooth_x = 0;
			smooth_y = 0;
			factor   = FACTOR_RESET;
			off_x    = '0;
			off_y    = '0;
			errors   = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_FACTOR:   factor = v;
				REG_OFFSET_X: off_x = v[SAMPLE_W-1:0];
				REG_OFFSET_Y: off_y = v[SAMPLE_W-1:0];
				default: ;
			endcase
		endfunction

		// one EMA step on the Q8 boxcar average; weights above 1.0 act as 1.0,
		// rounding is half up (arithmetic shift floors)
		function longint smooth_next(longint prev, int sum);
			longint avg;
			longint a;
			avg = longint'(sum) * AVG_SCALE;
			a = (factor > FACTOR_ONE) ? 64'sd65536 : longint'(factor);
			return (avg * a + prev * (64'sd65536 - a) + 64'sd32768) >>> 16;
		endfunction

		// Q8 counts equal g with 22 fraction bits, so only the offset and the clamp remain
		function logic signed [OUT_W-1:0] to_g(longint s, logic signed [SAMPLE_W-1:0] off);
			longint v;
			v = s - longint'(off) * 256;
			if (v > longint'(OUT_MAX))
				v = longint'(OUT_MAX);
			if (v < longint'(OUT_MIN))
				v = longint'(OUT_MIN);
			return v[OUT_W-1:0];
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] y);
			accel_pair_t e;
			sum_x = sum_x - ring_x[slot] + int'(x);
			ring_x[slot] = int'(x);
			sum_y = sum_y - ring_y[slot] + int'(y);
			ring_y[slot] = int'(y);
			slot = (slot + 1) % RING_DEPTH;
			smooth_x = smooth_next(smooth_x, sum_x);
			smooth_y = smooth_next(smooth_y, sum_y);
			e.ax = to_g(smooth_x, off_x);
			e.ay = to_g(smooth_y, off_y);
			pending_g.push_back(e);
		endfunction

		function void check_accel(logic signed [OUT_W-1:0] ax, logic signed [OUT_W-1:0] ay);
			accel_pair_t e;
			if (pending_g.size() == 0) begin
				errors++;
				$error("accel result %0d/%0d arrived with no sample pair pending", ax, ay);
				return;
			end
			e = pending_g.pop_front();
			if (ax !== e.ax) begin
				errors++;
				$error("accel_x_g mismatch: expected %0d, got %0d", e.ax, ax);
			end
			if (ay !== e.ay) begin
				errors++;
				$error("accel_y_g mismatch: expected %0d, got %0d", e.ay, ay);
			end
		endfunction

		function int pending();
			return pending_g.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	abef_sample_if sample_ch ();
	abef_accel_if  accel_ch ();

	accel_scoreboard sb = new();

	// set by the sender, cleared by the receiver once the hold-off is over
	bit hold_req = 1'b0;

	accel_boxcar_ema_filter_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.sample_ch (sample_ch),
		.accel_ch  (accel_ch)
	);

	// 4-unit clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Monitor: everything is sampled at the rising edge. Results are checked
	// before the input of the same edge is noted; the pipeline registers between
	// the two keep them from ever referring to the same item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (accel_ch.valid && accel_ch.ready)
				sb.check_accel(accel_ch.accel_x_g, accel_ch.accel_y_g);
			if (sample_ch.valid && sample_ch.ready)
				sb.note_sample(sample_ch.sample_x, sample_ch.sample_y);
		end
	end

	// Watchdog: a hang on either channel shows up as a long run of edges
	// with nothing accepted on either side.
	initial begin
		int idle_run;
		idle_run = 0;
		while (idle_run < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (accel_ch.valid && accel_ch.ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$error("watchdog: no item accepted for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: ready changes at the falling edge only. It switches between
	// stretches with no stalls and stretches with a random stall per result,
	// and on request holds ready low for a long stretch so the block backs up.
	initial begin
		int  stall;
		int  streak;
		bit  no_stall;
		accel_ch.ready = 1'b0;
		streak   = 0;
		no_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				@(negedge clk) accel_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
			end
			if (streak == 0) begin
				streak   = $urandom_range(10, 40);
				no_stall = ($urandom_range(0, 2) == 0);
			end
			streak--;
			stall = no_stall ? 0 : $urandom_range(0, 5);
			repeat (stall) @(negedge clk) accel_ch.ready <= 1'b0;
			@(negedge clk) accel_ch.ready <= 1'b1;
			do @(posedge clk); while (!accel_ch.valid);
		end
	end

	// Offer one sample pair and wait until it is taken. With gaps on, valid first
	// drops for a random gap, possibly none; otherwise the next pair follows back to back.
	task automatic send_pair(logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] y,
			bit gaps_on);
		int gap;
		gap = gaps_on ? $urandom_range(0, 5) : 0;
		repeat (gap) @(negedge clk) sample_ch.valid <= 1'b0;
		@(negedge clk) begin
			sample_ch.valid    <= 1'b1;
			sample_ch.sample_x <= x;
			sample_ch.sample_y <= y;
		end
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// stop offering and wait until every predicted result has been checked
	task automatic drain();
		@(negedge clk) sample_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// write enable stays high across back-to-back writes; the caller lowers it
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
		@(negedge clk) begin
			cfg_we    <= 1'b1;
			cfg_idx   <= idx;
			cfg_wdata <= v;
		end
		sb.set_reg(idx, v);
	endtask

	// registers only change with the block empty and settled
	task automatic configure(logic [CFG_W-1:0] f, logic signed [SAMPLE_W-1:0] ox,
			logic signed [SAMPLE_W-1:0] oy);
		drain();
		repeat (PIPE_SETTLE) @(negedge clk);
		write_reg(REG_FACTOR, f);
		write_reg(REG_OFFSET_X, {ox[SAMPLE_W-1], ox});
		write_reg(REG_OFFSET_Y, {oy[SAMPLE_W-1], oy});
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	// half full-range noise, some rail values, some small steps from the
	// last sample so the averages settle and track a slow signal
	function automatic logic [SAMPLE_W-1:0] draw_sample(logic [SAMPLE_W-1:0] prev);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return SAMPLE_W'($urandom);
			5:             return 16'h7FFF;
			6:             return 16'h8000;
			default:       return prev + SAMPLE_W'($urandom_range(0, 64)) - 16'd32;
		endcase
	endfunction

	initial begin
		logic [CFG_W-1:0]           f;
		logic signed [SAMPLE_W-1:0] ox;
		logic signed [SAMPLE_W-1:0] oy;
		logic signed [SAMPLE_W-1:0] sx;
		logic signed [SAMPLE_W-1:0] sy;
		bit                         gaps_on;
		int                         rush;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_idx            = REG_FACTOR;
		cfg_wdata          = '0;
		sample_ch.valid    = 1'b0;
		sample_ch.sample_x = '0;
		sample_ch.sample_y = '0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed part. Reset values of the registers first: zeros, both rails
		// on both axes and the smallest steps around zero.
		send_pair(16'sd0, 16'sd0, 1'b1);
		send_pair(16'sd32767, -16'sd32768, 1'b1);
		send_pair(-16'sd32768, 16'sd32767, 1'b1);
		send_pair(-16'sd1, 16'sd1, 1'b1);
		send_pair(16'sd1, -16'sd1, 1'b1);
		send_pair(16'sd32767, 16'sd32767, 1'b1);

		// weight exactly one with offset rails opposite to the samples: half of the
		// ring is then written with rail samples on both axes
		configure(FACTOR_ONE, -16'sd32768, 16'sd32767);
		repeat (8) send_pair(16'sd32767, -16'sd32768, 1'b1);

		// weight zero: the smoothed value must hold whatever the input does
		configure('0, 16'sd32767, -16'sd32768);
		repeat (3) send_pair(-16'sd32768, 16'sd32767, 1'b1);

		// weights above one behave as exactly one
		configure(17'h1FFFF, 16'sd0, 16'sd0);
		repeat (3) send_pair(16'sd12345, -16'sd12345, 1'b1);
		configure(FACTOR_ONE + 17'd1, 16'sd0, 16'sd0);
		repeat (2) send_pair(-16'sd32768, -16'sd32768, 1'b1);

		// Random part: one register setting per phase, edges of the weight range
		// picked often.
		sx = '0;
		sy = '0;
		gaps_on = 1'b1;
		rush = 0;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 7))
				0:       f = '0;
				1:       f = 17'd1;
				2:       f = FACTOR_ONE - 17'd1;
				3:       f = FACTOR_ONE;
				4:       f = FACTOR_ONE + 17'd1;
				5:       f = 17'h1FFFF;
				6:       f = CFG_W'($urandom_range(0, 65536));
				default: f = CFG_W'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0:       ox = -16'sd32768;
				1:       ox = 16'sd32767;
				default: ox = SAMPLE_W'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0:       oy = 16'sd32767;
				1:       oy = -16'sd32768;
				default: oy = SAMPLE_W'($urandom);
			endcase
			configure(f, ox, oy);

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 25 == 0)
					gaps_on = ($urandom_range(0, 2) != 0);
				// long receiver hold-off while pairs keep coming back to back
				if (p == 1 && i == 10) begin
					hold_req = 1'b1;
					rush = 30;
				end
				// mid-phase pause until every result is back
				if (p == 3 && i == 50)
					drain();
				sx = draw_sample(sx);
				sy = draw_sample(sy);
				if (rush > 0) begin
					rush--;
					send_pair(sx, sy, 1'b0);
				end else begin
					send_pair(sx, sy, gaps_on);
				end
			end
		end

		drain();
		repeat (PIPE_SETTLE * 2) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (sb.pending() != 0)
				$error("%0d expected results never arrived", sb.pending());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
